[src/wcvs_pkg.sv]
// Shared constants and types of the windowed class vote smoother.
package wcvs_pkg;

   // Default sizes of the block.
   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int MAX_CLASSES_DEFAULT = 8;
   localparam int SCORE_WIDTH_DEFAULT = 24;

   // The item always carries this many score fields.
   localparam int SCORE_PORTS = 8;

   // Q12.12 thresholds: instantaneous floor of -1000.0, average floor of -100.0.
   localparam int Q_ONE         = 4096;
   localparam int INST_FLOOR    = -1000 * Q_ONE;
   localparam int AVG_FLOOR_MAG = 100 * Q_ONE;

   // Configuration port.
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int WINDOW_LENGTH_W = 7;
   localparam int CLASS_COUNT_W   = 4;

   localparam logic [WINDOW_LENGTH_W-1:0] WINDOW_LENGTH_RESET = 7'd15;
   localparam logic [CLASS_COUNT_W-1:0]   CLASS_COUNT_RESET   = 4'd8;

   // Register index, taken from the word address of the configuration port.
   typedef enum logic [0:0] {
      REG_WINDOW_LENGTH = 1'b0,
      REG_CLASS_COUNT   = 1'b1
   } csr_index_type;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

endpackage

[src/wcvs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module wcvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/windowed_class_vote_smoother.sv]
// Windowed class vote smoother: one score vector per cycle in, one smoothed
// decision per cycle out. Each transaction on the request side carries one
// signed Q12.12 score per class. The block picks the instantaneous winner (the
// first active class with the strictly highest score above -1000.0), stores the
// scores and that winner in a ring of window_length slots, and keeps running
// per-class sums and vote counts, so no walk over the window is ever needed.
// Every request produces exactly one response: the class with the highest
// window average above -100.0, the class with the most votes, its vote count,
// and an unknown flag raised when the votes fall below three quarters of the
// window or no class clears the average floor. Throughput is one transaction
// per clock cycle while the response side does not stall, set by the single
// read and single write per cycle of the ring memory; a response passes the
// input register and the decision stage before it enters the four-entry output
// queue. The ring memory needs no clearing pass after reset: each slot has a
// valid bit, and an unwritten slot reads as zero scores and no vote. Writing
// either configuration register empties the window and restarts the slot
// pointer; do so only while no transaction is in flight.
module windowed_class_vote_smoother
   import wcvs_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT,
   parameter int SCORE_WIDTH = SCORE_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_0,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_1,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_2,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_3,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_4,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_5,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_6,
   input  logic signed [SCORE_WIDTH-1:0]             req_score_7,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [$clog2(MAX_CLASSES)-1:0]            rsp_average_winner,
   output logic [$clog2(MAX_CLASSES)-1:0]            rsp_vote_winner,
   output logic [$clog2(WINDOW_MAX + 1)-1:0]         rsp_winner_votes,
   output logic                                      rsp_unknown,

   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                     csr_paddr,
   input  logic [CSR_DATA_W-1:0]                     csr_pwdata,
   output logic [CSR_DATA_W-1:0]                     csr_prdata,
   output logic                                      csr_pready
);

   // Derived sizes.
   localparam int SLOT_W  = $clog2((WINDOW_MAX > 1) ? WINDOW_MAX : 2);
   localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
   localparam int VOTE_W  = LEN_W;
   localparam int CLS_W   = $clog2(MAX_CLASSES);
   localparam int WIN_W   = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W   = SCORE_WIDTH + SLOT_W;
   localparam int CMP_W   = (SUM_W > 29) ? SUM_W + 1 : 30;
   localparam int SCORES_W = MAX_CLASSES * SCORE_WIDTH;
   localparam int ROW_W   = SCORES_W + WIN_W;

   // A slot that was never written: zero scores and the no-vote code.
   localparam logic [ROW_W-1:0] EMPTY_ROW = {WIN_W'(MAX_CLASSES), {SCORES_W{1'b0}}};

   typedef struct packed {
      logic [CLS_W-1:0]  average_winner;
      logic [CLS_W-1:0]  vote_winner;
      logic [VOTE_W-1:0] winner_votes;
      logic              unknown;
   } result_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [WINDOW_LENGTH_W-1:0] window_length_ff;
   logic [CLASS_COUNT_W-1:0]   class_count_ff;
   logic                       csr_write;
   csr_index_type              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         class_count_ff   <= CLASS_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: window_length_ff <= csr_pwdata[WINDOW_LENGTH_W-1:0];
            REG_CLASS_COUNT:   class_count_ff   <= csr_pwdata[CLASS_COUNT_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WINDOW_LENGTH:
            csr_prdata = {{(CSR_DATA_W - WINDOW_LENGTH_W){1'b0}}, window_length_ff};
         REG_CLASS_COUNT:
            csr_prdata = {{(CSR_DATA_W - CLASS_COUNT_W){1'b0}}, class_count_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Effective window length and class count, with out-of-range values
   // pulled back into range.
   logic [LEN_W-1:0] eff_len;
   logic [WIN_W-1:0] eff_cls;

   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(window_length_ff) > WINDOW_MAX) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = LEN_W'(window_length_ff);
      end

      if (class_count_ff == '0) begin
         eff_cls = WIN_W'(1);
      end else if (int'(class_count_ff) > MAX_CLASSES) begin
         eff_cls = WIN_W'(MAX_CLASSES);
      end else begin
         eff_cls = WIN_W'(class_count_ff);
      end
   end

   // The average floor scaled by the window length, so that sums can be
   // compared directly without any division. Refreshed every cycle; the user must
   // make configuration changes only while the block is idle (not enforced here).
   logic signed [CMP_W-1:0] avg_floor_ff;

   always_ff @(posedge clock) begin
      avg_floor_ff <= -(CMP_W'(AVG_FLOOR_MAG) * CMP_W'(eff_len));
   end

   // ------------------------------------------------------------------
   // Request acceptance and slot pointer
   // ------------------------------------------------------------------
   logic signed [SCORE_WIDTH-1:0] req_scores [SCORE_PORTS];
   logic                          req_accept;
   logic [SLOT_W-1:0]             slot_ff;
   logic [SLOT_W-1:0]             slot_in;

   assign req_scores[0] = req_score_0;
   assign req_scores[1] = req_score_1;
   assign req_scores[2] = req_score_2;
   assign req_scores[3] = req_score_3;
   assign req_scores[4] = req_score_4;
   assign req_scores[5] = req_score_5;
   assign req_scores[6] = req_score_6;
   assign req_scores[7] = req_score_7;

   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      slot_in = slot_ff;
      if (req_accept) begin
         if (int'(slot_ff) + 1 >= int'(eff_len)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Input register. The ring slot for the transaction is read from memory
   // at the same edge, so its old contents are ready alongside the scores.
   // ------------------------------------------------------------------
   logic                          in_valid_ff;
   logic [SLOT_W-1:0]             in_slot_ff;
   logic signed [SCORE_WIDTH-1:0] in_score_ff [MAX_CLASSES];
   logic                          rd_row_valid_ff;
   logic                          bypass_ff;
   logic [ROW_W-1:0]              bypass_row_ff;
   logic [ROW_W-1:0]              ram_rd_data;
   logic [WINDOW_MAX-1:0]         row_valid_ff;
   logic [ROW_W-1:0]              new_row;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_slot_ff      <= slot_ff;
         rd_row_valid_ff <= row_valid_ff[slot_ff];
         // The transaction ahead writes its slot at this very edge; when that
         // is the slot being read (a window of one), its new row is forwarded.
         bypass_ff       <= in_valid_ff && (in_slot_ff == slot_ff);
         bypass_row_ff   <= new_row;
         for (int k = 0; k < MAX_CLASSES; k++) begin
            in_score_ff[k] <= req_scores[k];
         end
      end
   end

   wcvs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (in_valid_ff),
      .wr_addr (in_slot_ff),
      .wr_data (new_row),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Update stage: instantaneous winner, new ring row, running sums and
   // vote counts.
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]        old_row;
   logic [WIN_W-1:0]        old_winner;
   logic [WIN_W-1:0]        inst_winner;
   logic signed [SUM_W-1:0] sums_ff  [MAX_CLASSES];
   logic signed [SUM_W-1:0] sums_in  [MAX_CLASSES];
   logic [VOTE_W-1:0]       votes_ff [MAX_CLASSES];
   logic [VOTE_W-1:0]       votes_in [MAX_CLASSES];

   always_comb begin
      if (bypass_ff) begin
         old_row = bypass_row_ff;
      end else if (rd_row_valid_ff) begin
         old_row = ram_rd_data;
      end else begin
         old_row = EMPTY_ROW;
      end
   end

   assign old_winner = old_row[ROW_W-1 -: WIN_W];

   always_comb begin
      logic signed [CMP_W-1:0]       best;
      logic signed [SCORE_WIDTH-1:0] new_score;
      logic signed [SCORE_WIDTH-1:0] old_score;
      logic [VOTE_W-1:0]             count;

      best        = CMP_W'(INST_FLOOR);
      inst_winner = WIN_W'(MAX_CLASSES);
      new_row     = '0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
         // Inactive classes are stored as zero and never win.
         if (k < int'(eff_cls)) begin
            new_score = in_score_ff[k];
            if (CMP_W'(new_score) > best) begin
               best        = CMP_W'(new_score);
               inst_winner = WIN_W'(k);
            end
         end else begin
            new_score = '0;
         end
         new_row[k*SCORE_WIDTH +: SCORE_WIDTH] = new_score;

         old_score  = old_row[k*SCORE_WIDTH +: SCORE_WIDTH];
         sums_in[k] = sums_ff[k] - SUM_W'(old_score) + SUM_W'(new_score);
      end
      new_row[ROW_W-1 -: WIN_W] = inst_winner;

      // The departing vote leaves before the new one arrives.
      for (int k = 0; k < MAX_CLASSES; k++) begin
         count = votes_ff[k];
         if ((old_winner == WIN_W'(k)) && (count != '0)) begin
            count = count - VOTE_W'(1);
         end
         if (inst_winner == WIN_W'(k)) begin
            count = count + VOTE_W'(1);
         end
         votes_in[k] = count;
      end
   end

   // Window state: cleared by reset and by any configuration write.
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         slot_ff      <= '0;
         row_valid_ff <= '0;
         for (int k = 0; k < MAX_CLASSES; k++) begin
            sums_ff[k]  <= '0;
            votes_ff[k] <= '0;
         end
      end else begin
         slot_ff <= slot_in;
         if (in_valid_ff) begin
            row_valid_ff[in_slot_ff] <= 1'b1;
            for (int k = 0; k < MAX_CLASSES; k++) begin
               sums_ff[k]  <= sums_in[k];
               votes_ff[k] <= votes_in[k];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Decision stage: in the cycle after the update, the sums and counts hold
   // exactly this transaction's window.
   // ------------------------------------------------------------------
   logic       s2_valid_ff;
   result_type decision;

   always_comb begin
      logic signed [CMP_W-1:0] best_sum;
      logic                    have_avg;
      logic [VOTE_W-1:0]       best_votes;

      best_sum   = avg_floor_ff;
      have_avg   = 1'b0;
      best_votes = '0;
      decision   = '0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
         if (k < int'(eff_cls)) begin
            if (CMP_W'(sums_ff[k]) > best_sum) begin
               best_sum                = CMP_W'(sums_ff[k]);
               have_avg                = 1'b1;
               decision.average_winner = CLS_W'(k);
            end
            if (votes_ff[k] > best_votes) begin
               best_votes           = votes_ff[k];
               decision.vote_winner = CLS_W'(k);
            end
         end
      end
      decision.winner_votes = best_votes;
      decision.unknown      = ~have_avg || (int'(best_votes) * 4 < int'(eff_len) * 3);
   end

   // ------------------------------------------------------------------
   // Result queue. The request side is held off while the queue plus the
   // transactions still in the pipeline could fill it.
   // ------------------------------------------------------------------
   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] occupancy;
   logic                  rsp_pop;
   result_type            head;

   assign rsp_pop   = rsp_valid & ~rsp_stall;
   assign occupancy = count_ff + FIFO_CNT_W'(in_valid_ff) + FIFO_CNT_W'(s2_valid_ff);
   assign req_stall = (int'(occupancy) >= FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= req_accept;
         s2_valid_ff <= in_valid_ff;
         if (s2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_ff + FIFO_CNT_W'(s2_valid_ff) - FIFO_CNT_W'(rsp_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= decision;
      end
   end

   assign head               = fifo_ff[rd_ptr_ff];
   assign rsp_valid          = (count_ff != '0);
   assign rsp_average_winner = head.average_winner;
   assign rsp_vote_winner    = head.vote_winner;
   assign rsp_winner_votes   = head.winner_votes;
   assign rsp_unknown        = head.unknown;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // The queue and the pipeline together never hold more than the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      int'(occupancy) <= FIFO_DEPTH)
      else $error("result queue overcommitted");

   // The slot pointer always stays inside the effective window.
   assert property (@(posedge clock) disable iff (reset)
      int'(slot_ff) < int'(eff_len))
      else $error("slot pointer outside the window");

   // Every transaction in the update stage reaches the decision stage next.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> s2_valid_ff)
      else $error("transaction lost between update and decision");

endmodule
